// ===== src/lcd_serial_command_data_writer_top_assert.svh =====
// ----------------------------------------------------------------------------
// LCD serial writer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_SERIAL_COMMAND_DATA_WRITER_TOP_ASSERT_SVH
`define LCD_SERIAL_COMMAND_DATA_WRITER_TOP_ASSERT_SVH

// Same-cycle implication
`define LCDW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LCDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD serial writer package
// Request codes, register indexes, reset values and the decoded command type.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  // Request codes carried in the action field
  typedef enum logic [2:0] {
    ActData     = 3'd0,
    ActCmd      = 3'd1,
    ActPage     = 3'd2,
    ActColumn   = 3'd3,
    ActContrast = 3'd4
  } action_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgPanelWidth   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgColumnOffset = 1'd1;

  localparam logic [7:0] PanelWidthRst   = 8'd96;
  localparam logic [7:0] ColumnOffsetRst = 8'd18;

  // Controller command bytes
  localparam logic [7:0] CmdPageBase   = 8'hB0;
  localparam logic [7:0] CmdColHiBase  = 8'h10;
  localparam logic [7:0] CmdContrast   = 8'h81;
  localparam logic [7:0] NibbleMask    = 8'h0F;
  localparam logic [7:0] ContrastMask  = 8'h3F;

  // Pin states per byte: 16 bit states plus the closing state
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepClose = 5'd16;

  // One decoded request: one or two bytes to shift out
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two_bytes;
    logic       data_mode;
  } cmd_t;

endpackage

// ===== src/lcdw_if.sv =====
// ----------------------------------------------------------------------------
// LCD serial writer channels
// Request, pin-state and configuration handshake interfaces.
// ----------------------------------------------------------------------------

// Request channel
interface lcdw_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] value;
  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// Pin-state result channel
interface lcdw_pin_if;
  logic valid;
  logic ready;
  logic serial_data;
  logic serial_clock;
  logic data_mode;
  logic chip_deselect;
  logic reset_line;
  logic last;
  modport source (output valid, output serial_data, output serial_clock,
                  output data_mode, output chip_deselect, output reset_line,
                  output last, input ready);
  modport sink   (input valid, input serial_data, input serial_clock,
                  input data_mode, input chip_deselect, input reset_line,
                  input last, output ready);
endinterface

// Configuration write channel
interface lcdw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lcdw_pkg::CfgIdxW-1:0] index;
  logic [7:0]                   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/lcd_serial_command_data_writer_top.sv =====
// ----------------------------------------------------------------------------
// LCD serial command/data writer
// Turns display requests into serial pin states for a page-addressed LCD.
// ----------------------------------------------------------------------------
// Port    Dir  Beat contents
// cfg_i   in   index (0 panel width, 1 column offset), data
// req_i   in   action, value
// pin_o   out  serial_data, serial_clock, data_mode, chip_deselect,
//              reset_line, last
//
// A request yields 0, 17 or 34 pin-state beats, one per cycle at full speed.
// Unstalled, the shifter emits one pin state per cycle; a decoded request
// waits in a command register, so back-to-back requests stream with no gap.
// A stall on pin_o holds the current state; req_i backs up after one request.
// Reset clears the column counter and loads width 96, offset 18.
// ----------------------------------------------------------------------------
module lcd_serial_command_data_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcdw_cfg_if.sink    cfg_i,
  lcdw_req_if.sink    req_i,
  lcdw_pin_if.source  pin_o
);

  lcdw_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           take;

  lcdw_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .take_i      (take),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  lcdw_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .take_o      (take),
    .pin_o       (pin_o)
  );

endmodule

// ===== src/lcdw_decode.sv =====
// ----------------------------------------------------------------------------
// LCD serial writer request decoder
// Holds configuration and column state; turns a request into a command register.
// ----------------------------------------------------------------------------
module lcdw_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcdw_req_if.sink          req_i,
  lcdw_cfg_if.sink          cfg_i,
  input  logic              take_i,
  output lcdw_pkg::cmd_t    cmd_o,
  output logic              cmd_valid_o
);

  logic [7:0]     panel_width_q, column_offset_q;
  logic [7:0]     col_q, col_d;
  logic           pend_q, pend_d;
  lcdw_pkg::cmd_t cmd_q, cmd_d;
  logic           has_out;
  logic           accept;
  logic [7:0]     col_sum;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !pend_q || take_i;
  assign accept      = req_i.valid && req_i.ready;
  assign col_sum     = req_i.value + column_offset_q;

  // Request decode
  always_comb begin
    has_out = 1'b0;
    col_d   = col_q;
    cmd_d   = '0;
    unique case (lcdw_pkg::action_e'(req_i.action))
      lcdw_pkg::ActData: begin
        if (col_q < panel_width_q) begin
          has_out         = 1'b1;
          cmd_d.byte0     = req_i.value;
          cmd_d.data_mode = 1'b1;
          col_d           = col_q + 8'd1;
        end
      end
      lcdw_pkg::ActCmd: begin
        has_out     = 1'b1;
        cmd_d.byte0 = req_i.value;
      end
      lcdw_pkg::ActPage: begin
        has_out     = 1'b1;
        cmd_d.byte0 = lcdw_pkg::CmdPageBase | (req_i.value & lcdw_pkg::NibbleMask);
      end
      lcdw_pkg::ActColumn: begin
        has_out         = 1'b1;
        col_d           = req_i.value;
        cmd_d.byte0     = lcdw_pkg::CmdColHiBase | {4'd0, col_sum[7:4]};
        cmd_d.byte1     = col_sum & lcdw_pkg::NibbleMask;
        cmd_d.two_bytes = 1'b1;
      end
      lcdw_pkg::ActContrast: begin
        has_out         = 1'b1;
        cmd_d.byte0     = lcdw_pkg::CmdContrast;
        cmd_d.byte1     = req_i.value & lcdw_pkg::ContrastMask;
        cmd_d.two_bytes = 1'b1;
      end
      default: begin
        has_out = 1'b0;
      end
    endcase
  end

  // Pending command occupancy
  always_comb begin
    pend_d = pend_q && !take_i;
    if (accept) begin
      pend_d = has_out;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q   <= lcdw_pkg::PanelWidthRst;
      column_offset_q <= lcdw_pkg::ColumnOffsetRst;
      col_q           <= 8'd0;
      pend_q          <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        col_q <= col_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          lcdw_pkg::CfgPanelWidth:   panel_width_q   <= cfg_i.data;
          lcdw_pkg::CfgColumnOffset: column_offset_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // Command payload
  always_ff @(posedge clk_i) begin
    if (accept && has_out) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = pend_q;

endmodule

// ===== src/lcdw_serial.sv =====
// ----------------------------------------------------------------------------
// LCD serial writer shifter
// Walks one command through 17 pin states per byte, MSB first.
// ----------------------------------------------------------------------------
`include "lcd_serial_command_data_writer_top_assert.svh"

module lcdw_serial (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lcdw_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           take_o,
  lcdw_pin_if.source     pin_o
);

  lcdw_pkg::cmd_t                cmd_q;
  logic                          active_q, active_d;
  logic                          second_q, second_d;
  logic [lcdw_pkg::StepW-1:0]    step_q, step_d;
  logic [7:0]                    cur_byte;
  logic [2:0]                    bit_sel;
  logic                          is_close, is_last, fire, load;

  assign cur_byte = second_q ? cmd_q.byte1 : cmd_q.byte0;
  assign bit_sel  = ~step_q[3:1];
  assign is_close = (step_q == lcdw_pkg::StepClose);
  assign is_last  = is_close && (!cmd_q.two_bytes || second_q);
  assign fire     = pin_o.valid && pin_o.ready;
  assign take_o   = !active_q || (fire && is_last);
  assign load     = take_o && cmd_valid_i;

  // Step sequencing
  always_comb begin
    active_d = active_q;
    second_d = second_q;
    step_d   = step_q;
    if (fire) begin
      if (is_close) begin
        if (is_last) begin
          active_d = 1'b0;
        end else begin
          second_d = 1'b1;
          step_d   = '0;
        end
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    if (load) begin
      active_d = 1'b1;
      second_d = 1'b0;
      step_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      second_q <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      second_q <= second_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

  // Pin levels for the current state
  assign pin_o.valid         = active_q;
  assign pin_o.serial_data   = !is_close && cur_byte[bit_sel];
  assign pin_o.serial_clock  = !is_close && step_q[0];
  assign pin_o.data_mode     = cmd_q.data_mode;
  assign pin_o.chip_deselect = is_close;
  assign pin_o.reset_line    = 1'b1;
  assign pin_o.last          = is_last;

  `LCDW_ASSERT_SAME(a_step_range, active_q, step_q <= lcdw_pkg::StepClose,
                    "step counter past closing state")
  `LCDW_ASSERT_SAME(a_second_two, active_q && second_q, cmd_q.two_bytes,
                    "second byte on a single-byte command")
  `LCDW_ASSERT_SAME(a_data_single, active_q && cmd_q.data_mode, !cmd_q.two_bytes,
                    "display data command with two bytes")
  `LCDW_ASSERT_NEXT(a_stall_hold, active_q && !pin_o.ready,
                    active_q && $stable(step_q) && $stable(second_q),
                    "pin state moved while stalled")

endmodule
